>>> rtl/etc_pkg.sv
// shared constants and types for the epoch seconds to calendar converter
package etc_pkg;

  // pipeline depth
  localparam int unsigned NSTAGE = 15;

  // time of day constants
  localparam logic [9:0]  SECS_DAY_LO  = 10'd675;        // seconds per day over 128
  localparam logic [23:0] RECIP_675    = 24'd12725829;   // floor(2^33 / 675)
  localparam logic [11:0] SECS_HOUR    = 12'd3600;
  localparam logic [5:0]  RECIP_HOUR   = 6'd36;          // floor(2^17 / 3600)
  localparam logic [5:0]  SECS_MIN     = 6'd60;
  localparam logic [6:0]  RECIP_MIN    = 7'd68;          // floor(2^12 / 60)
  localparam logic [2:0]  EPOCH_WDAY   = 3'd4;           // first epoch day was a thursday

  // date constants
  localparam logic [23:0] DAYS_TO_MARCH = 24'd719468;
  localparam logic [17:0] DAYS_400Y     = 18'd146097;
  localparam logic [8:0]  RECIP_400Y    = 9'd459;        // floor(2^26 / 146097)
  localparam logic [21:0] YEAR_MUL      = 22'd2939745;
  localparam logic [23:0] YEAR_DIV      = 24'd11758980;  // four times the year multiplier
  localparam logic [8:0]  RECIP_YEAR    = 9'd365;        // floor(2^32 / 11758980)
  localparam logic [11:0] MONTH_MUL     = 12'd2141;
  localparam logic [19:0] MONTH_ADD     = 20'd132377;
  localparam logic [4:0]  RECIP_MONTH   = 5'd30;         // floor(2^16 / 2141)
  localparam logic [8:0]  MARCH_TO_JAN  = 9'd306;
  localparam logic [8:0]  DAYS_JAN_FEB  = 9'd59;
  localparam logic [3:0]  MONTHS_YEAR   = 4'd12;
  localparam logic [6:0]  YEARS_CENT    = 7'd100;
  localparam logic [15:0] YEAR_BASE     = 16'd1900;

  // handshake control between the valid chain and the datapath
  typedef struct packed {
    logic [NSTAGE-1:0] load;
    logic              in_ready;
    logic              out_valid;
  } pipe_ctrl_t;

  // working values carried down the pipeline
  typedef struct packed {
    logic [32:0] x;
    logic [6:0]  t_lo;
    logic [23:0] days;
    logic [10:0] r675;
    logic [16:0] secs;
    logic [25:0] nc;
    logic [5:0]  wsum;
    logic [2:0]  wday;
    logic [4:0]  hour;
    logic [12:0] r3600;
    logic [8:0]  cent;
    logic [18:0] ncr;
    logic [15:0] dcent;
    logic [5:0]  mins;
    logic [6:0]  r60;
    logic [5:0]  sec;
    logic [7:0]  ycent;
    logic [31:0] low;
    logic [8:0]  dyear;
    logic [24:0] dyr;
    logic [15:0] year;
    logic        leap;
    logic [19:0] nm;
    logic [4:0]  mday;
    logic [12:0] mdr;
    logic [3:0]  month;
    logic [8:0]  yday;
  } item_t;

endpackage

>>> rtl/etc_pipe_ctrl.sv
// valid chain and per-stage load enables for the converter pipeline
module etc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output etc_pkg::pipe_ctrl_t ctrl
);

  logic [etc_pkg::NSTAGE-1:0] valid;
  logic [etc_pkg::NSTAGE-1:0] load;
  logic [etc_pkg::NSTAGE-1:0] mask;
  logic                       in_acc;
  logic                       out_acc;

  // a stage may load when some stage at or downstream of it is empty, or the output drains
  always_comb begin
    for (int i = 0; i < etc_pkg::NSTAGE; i++) begin
      mask    = {etc_pkg::NSTAGE{1'b1}} << i;
      load[i] = out_ready || ((valid & mask) != mask);
    end
  end

  // valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < etc_pkg::NSTAGE; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.load      = load;
  assign ctrl.in_ready  = load[0];
  assign ctrl.out_valid = valid[etc_pkg::NSTAGE-1];

  assign in_acc  = in_valid && load[0];
  assign out_acc = valid[etc_pkg::NSTAGE-1] && out_ready;

  // input held off only when every stage holds an item
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !ctrl.in_ready |-> (&valid))
    else $error("input blocked while a stage is empty");

  // an empty output stage always lets an item in
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !valid[etc_pkg::NSTAGE-1] |-> ctrl.in_ready)
    else $error("input blocked with empty output stage");

  // items in flight change only by accepted inputs and outputs
  a_item_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(valid) == $past($countones(valid))
              + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or duplicated in pipeline");

endmodule

>>> rtl/epoch_seconds_to_calendar.sv
// Converts seconds since the 1970 epoch into broken-down Gregorian date and time.
//
// Input channel s_axis_*: one item is a 40-bit unsigned count of seconds.
// Output channel m_axis_*: one item per input, carrying years since 1900, month,
// day of month, hour, minute, second, weekday and day of year.
// Both channels transfer an item when tvalid and tready are high at a clock edge.
//
// An accepted input passes through the 15 register stages before its result
// can be taken on m_axis. Throughput is one item per cycle while the receiver
// takes results; each stage holds about one constant multiply or one subtract
// and compare of the reciprocal divisions.
// Reset (rst, synchronous) empties the pipeline; results in flight are dropped.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// s_axis_tready stays high until all 15 stages hold an item; nothing is lost
// or repeated and the waiting result stays stable on m_axis_tdata.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // epoch_seconds[39:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // years_since_1900[15:0], month_index[19:16], day_of_month[24:20],
  // hour_of_day[29:25], minute_of_hour[35:30], second_of_minute[41:36],
  // weekday[44:42], year_day[53:45], zero[55:54]
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned NS = etc_pkg::NSTAGE;

  etc_pkg::pipe_ctrl_t ctrl;
  etc_pkg::item_t      pipe [NS];
  etc_pkg::item_t      nxt  [NS];

  logic [56:0] p_day;
  logic [33:0] p_r675;
  logic [23:0] wshift;
  logic [21:0] p_hour;
  logic [34:0] p_cent;
  logic [3:0]  wfold;
  logic [2:0]  wmod;
  logic [16:0] p_r3600;
  logic [26:0] p_ncr;
  logic [18:0] p_min;
  logic [39:0] p_year;
  logic [11:0] p_r60;
  logic [40:0] p_dyear;
  logic [32:0] p_dyr;
  logic [20:0] p_mday;
  logic [16:0] p_mdr;

  etc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .ctrl      (ctrl)
  );

  // stage logic, each stage works on the register before it
  always_comb begin
    nxt[0] = '0;
    for (int i = 1; i < NS; i++) begin
      nxt[i] = pipe[i-1];
    end

    // day count estimate from seconds over 128
    nxt[0].x    = s_axis_tdata[39:7];
    nxt[0].t_lo = s_axis_tdata[6:0];
    p_day       = 57'(nxt[0].x) * 57'(etc_pkg::RECIP_675);
    nxt[0].days = p_day[56:33];

    // remainder of the day estimate
    p_r675      = 34'(pipe[0].x) - 34'(pipe[0].days) * 34'(etc_pkg::SECS_DAY_LO);
    nxt[1].r675 = p_r675[10:0];

    // fix the day count, seconds within the day
    if (pipe[1].r675 >= 11'(etc_pkg::SECS_DAY_LO)) begin
      nxt[2].days = pipe[1].days + 24'd1;
      nxt[2].r675 = pipe[1].r675 - 11'(etc_pkg::SECS_DAY_LO);
    end
    nxt[2].secs = {nxt[2].r675[9:0], pipe[1].t_lo};

    // shift to the march-based calendar, weekday digit sum, hour estimate
    nxt[3].nc = {pipe[2].days + etc_pkg::DAYS_TO_MARCH, 2'b11};
    wshift    = pipe[2].days + 24'(etc_pkg::EPOCH_WDAY);
    nxt[3].wsum = '0;
    for (int j = 0; j < 8; j++) begin
      nxt[3].wsum = nxt[3].wsum + 6'(wshift[3*j +: 3]);
    end
    p_hour      = 22'(pipe[2].secs) * 22'(etc_pkg::RECIP_HOUR);
    nxt[3].hour = p_hour[21:17];

    // 400-year cycle estimate, weekday fold, hour remainder
    p_cent      = 35'(pipe[3].nc) * 35'(etc_pkg::RECIP_400Y);
    nxt[4].cent = p_cent[34:26];
    wfold       = 4'(pipe[3].wsum[5:3]) + 4'(pipe[3].wsum[2:0]);
    wmod        = (wfold >= 4'd7) ? 3'(wfold - 4'd7) : wfold[2:0];
    nxt[4].wday = (wmod == 3'd7) ? 3'd0 : wmod;
    p_r3600      = 17'(pipe[3].secs) - 17'(pipe[3].hour) * 17'(etc_pkg::SECS_HOUR);
    nxt[4].r3600 = p_r3600[12:0];

    // remainder within the 400-year cycle, fix the hour
    p_ncr      = 27'(pipe[4].nc) - 27'(pipe[4].cent) * 27'(etc_pkg::DAYS_400Y);
    nxt[5].ncr = p_ncr[18:0];
    if (pipe[4].r3600 >= 13'(etc_pkg::SECS_HOUR)) begin
      nxt[5].hour  = pipe[4].hour + 5'd1;
      nxt[5].r3600 = pipe[4].r3600 - 13'(etc_pkg::SECS_HOUR);
    end

    // fix the cycle count, day within the cycle, minute estimate
    if (pipe[5].ncr >= 19'(etc_pkg::DAYS_400Y)) begin
      nxt[6].cent = pipe[5].cent + 9'd1;
      nxt[6].ncr  = pipe[5].ncr - 19'(etc_pkg::DAYS_400Y);
    end
    nxt[6].dcent = nxt[6].ncr[17:2];
    p_min        = 19'(pipe[5].r3600[11:0]) * 19'(etc_pkg::RECIP_MIN);
    nxt[6].mins  = p_min[17:12];

    // year within the cycle and its fraction, minute remainder
    p_year       = 40'({pipe[6].dcent, 2'b11}) * 40'(etc_pkg::YEAR_MUL);
    nxt[7].ycent = p_year[39:32];
    nxt[7].low   = p_year[31:0];
    p_r60        = pipe[6].r3600[11:0] - 12'(pipe[6].mins) * 12'(etc_pkg::SECS_MIN);
    nxt[7].r60   = p_r60[6:0];

    // day of computational year estimate, fix the minute
    p_dyear      = 41'(pipe[7].low) * 41'(etc_pkg::RECIP_YEAR);
    nxt[8].dyear = p_dyear[40:32];
    if (pipe[7].r60 >= 7'(etc_pkg::SECS_MIN)) begin
      nxt[8].mins = pipe[7].mins + 6'd1;
      nxt[8].sec  = 6'(pipe[7].r60 - 7'(etc_pkg::SECS_MIN));
    end else begin
      nxt[8].sec  = pipe[7].r60[5:0];
    end

    // day of year remainder, full year and leap flag
    p_dyr       = 33'(pipe[8].low) - 33'(pipe[8].dyear) * 33'(etc_pkg::YEAR_DIV);
    nxt[9].dyr  = p_dyr[24:0];
    nxt[9].year = 16'(pipe[8].cent) * 16'(etc_pkg::YEARS_CENT) + 16'(pipe[8].ycent);
    nxt[9].leap = (pipe[8].ycent != 8'd0) ? (pipe[8].ycent[1:0] == 2'd0)
                                          : (pipe[8].cent[1:0] == 2'd0);

    // fix the day of the computational year
    if (pipe[9].dyr >= 25'(etc_pkg::YEAR_DIV)) begin
      nxt[10].dyear = pipe[9].dyear + 9'd1;
    end

    // month and day fraction
    nxt[11].nm = 20'(pipe[10].dyear) * 20'(etc_pkg::MONTH_MUL) + etc_pkg::MONTH_ADD;

    // day of month estimate, back to january-based year
    p_mday       = 21'(pipe[11].nm[15:0]) * 21'(etc_pkg::RECIP_MONTH);
    nxt[12].mday = p_mday[20:16];
    if (pipe[11].dyear >= etc_pkg::MARCH_TO_JAN) begin
      nxt[12].year  = pipe[11].year + 16'd1;
      nxt[12].month = pipe[11].nm[19:16] - etc_pkg::MONTHS_YEAR;
      nxt[12].yday  = pipe[11].dyear - etc_pkg::MARCH_TO_JAN;
    end else begin
      nxt[12].month = pipe[11].nm[19:16];
      nxt[12].yday  = pipe[11].dyear + etc_pkg::DAYS_JAN_FEB + 9'(pipe[11].leap);
    end

    // day of month remainder
    p_mdr       = 17'(pipe[12].nm[15:0]) - 17'(pipe[12].mday) * 17'(etc_pkg::MONTH_MUL);
    nxt[13].mdr = p_mdr[12:0];

    // fix day of month, one-based days, year offset
    nxt[14].mday = (pipe[13].mdr >= 13'(etc_pkg::MONTH_MUL)) ? pipe[13].mday + 5'd2
                                                             : pipe[13].mday + 5'd1;
    nxt[14].yday = pipe[13].yday + 9'd1;
    nxt[14].year = pipe[13].year - etc_pkg::YEAR_BASE;
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ctrl.load[i]) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  assign s_axis_tready = ctrl.in_ready;
  assign m_axis_tvalid = ctrl.out_valid;
  assign m_axis_tdata  = {2'b00,
                          pipe[NS-1].yday,
                          pipe[NS-1].wday,
                          pipe[NS-1].sec,
                          pipe[NS-1].mins,
                          pipe[NS-1].hour,
                          pipe[NS-1].mday,
                          pipe[NS-1].month,
                          pipe[NS-1].year};

endmodule
